### hw/rtl/nre_pkg.sv
`default_nettype none
package nre_pkg;

    localparam int MAX_NUCLEI = 64;
    localparam int ADDR_W     = $clog2(MAX_NUCLEI);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int COORD_W  = 32;
    localparam int CHARGE_W = 7;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SUMSQ_W  = 2 * COORD_W + 2;
    localparam int ROOT_W   = COORD_W + 2;
    localparam int QQ_W     = 2 * CHARGE_W;
    localparam int TERM_W   = QQ_W + COORD_W;
    localparam int ENERGY_W = 48;
    localparam int ENTRY_W  = 3 * COORD_W + CHARGE_W;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_COINCIDENT = 2'd1;
    localparam logic [1:0] STAT_TOO_MANY   = 2'd2;
    localparam logic [1:0] STAT_SATURATED  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_PAIR,
        S_ACC,
        S_STORE,
        S_FINISH
    } top_state_t;

    typedef enum logic [2:0] {
        PU_IDLE,
        PU_SQ,
        PU_ROOT,
        PU_DIV,
        PU_DONE
    } pu_state_t;

    typedef struct packed {
        logic              done;
        logic              zero;
        logic [TERM_W-1:0] term;
    } pair_res_t;

endpackage
`default_nettype wire

### hw/rtl/nuclear_repulsion_energy.sv
`default_nettype none
// Nuclear repulsion energy. Send one nucleus per beat; the beat with tlast
// yields one result beat with the total energy (unsigned Q32.16, saturating)
// and a status code, after which the nucleus store is cleared. Each new
// nucleus is paired with every nucleus held so far, one pair at a time,
// through a bit-serial unit: shift-add squaring of the three differences,
// 33 square-root steps and 46 division steps, after the store read and the
// difference and before the result and the accumulate (a coincident pair
// skips the division). At most 63 nuclei are held when a new one is paired.
module nuclear_repulsion_energy (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [103:0] s_tdata,  // pos_x[31:0], pos_y[63:32], pos_z[95:64], charge[102:96]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata   // energy[47:0], status[49:48]
);
    import nre_pkg::*;

    top_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [ENERGY_W-1:0]   acc_reg, acc_next;
    logic [1:0]            status_reg, status_next;
    logic [COORD_W-1:0]    x_reg, y_reg, z_reg;
    logic [CHARGE_W-1:0]   q_reg;
    logic                  last_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [ENERGY_W+1:0]   m_data_reg, m_data_next;

    logic [ENTRY_W-1:0]    mem [MAX_NUCLEI];
    logic [ENTRY_W-1:0]    rd_reg;

    logic                  start;
    logic [DIFF_W-1:0]     dx, dy, dz, ax, ay, az;
    logic [QQ_W-1:0]       qq;
    logic [ENERGY_W:0]     sum;
    logic [1:0]            raise;
    pair_res_t             pres;

    nre_pair_unit u_pair (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .ax      (ax),
        .ay      (ay),
        .az      (az),
        .qq      (qq),
        .res     (pres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            acc_reg     <= '0;
            status_reg  <= STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
        if (s_tvalid && s_tready) begin
            x_reg    <= s_tdata[31:0];
            y_reg    <= s_tdata[63:32];
            z_reg    <= s_tdata[95:64];
            q_reg    <= s_tdata[102:96];
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_STORE) begin
            mem[count_reg[ADDR_W-1:0]] <= {q_reg, z_reg, y_reg, x_reg};
        end
        if (state_reg == S_READ) begin
            rd_reg <= mem[k_reg[ADDR_W-1:0]];
        end
    end

    assign dx = {x_reg[COORD_W-1], x_reg} - {rd_reg[COORD_W-1], rd_reg[COORD_W-1:0]};
    assign dy = {y_reg[COORD_W-1], y_reg}
              - {rd_reg[2*COORD_W-1], rd_reg[2*COORD_W-1:COORD_W]};
    assign dz = {z_reg[COORD_W-1], z_reg}
              - {rd_reg[3*COORD_W-1], rd_reg[3*COORD_W-1:2*COORD_W]};
    assign ax = dx[DIFF_W-1] ? -dx : dx;
    assign ay = dy[DIFF_W-1] ? -dy : dy;
    assign az = dz[DIFF_W-1] ? -dz : dz;
    assign qq = QQ_W'(q_reg * rd_reg[ENTRY_W-1:3*COORD_W]);
    assign sum = {1'b0, acc_reg} + {{(ENERGY_W+1-TERM_W){1'b0}}, pres.term};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        raise        = STAT_OK;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        start        = 1'b0;
        s_tready     = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    k_next = '0;
                    if (count_reg >= CNT_W'(MAX_NUCLEI)) begin
                        state_next = S_FINISH;
                    end else if (count_reg == '0) begin
                        state_next = S_STORE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_DIFF;
            end
            S_DIFF: begin
                start      = 1'b1;
                state_next = S_PAIR;
            end
            S_PAIR: begin
                if (pres.done) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                if (pres.zero) begin
                    raise = STAT_COINCIDENT;
                end else if (sum[ENERGY_W]) begin
                    acc_next = ENERGY_MAX;
                    raise    = STAT_SATURATED;
                end else begin
                    acc_next = sum[ENERGY_W-1:0];
                end
                k_next = k_reg + 1'b1;
                if (k_next == count_reg) begin
                    state_next = S_STORE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_STORE: begin
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (count_reg >= CNT_W'(MAX_NUCLEI) && k_reg == '0 && !last_reg) begin
                    raise = STAT_TOO_MANY;
                end
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {status_reg, acc_reg};
                    count_next   = '0;
                    acc_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        status_next = (raise > status_reg) ? raise : status_reg;
        if (state_reg == S_FINISH && last_reg && (!m_valid_reg || m_tready)) begin
            // fold in a too-many event carried by this last beat, then clear
            status_next = STAT_OK;
            if (count_reg >= CNT_W'(MAX_NUCLEI) && k_reg == '0
                && STAT_TOO_MANY > status_reg) begin
                m_data_next = {STAT_TOO_MANY, acc_reg};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    // at the count limit, k_reg is zero only on the path that skipped pairing and storing
    // (a stored nucleus always leaves count below the limit before its store)

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_NUCLEI))
        else $error("nucleus count beyond store depth");

    a_done_in_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        pres.done |-> state_reg == S_PAIR)
        else $error("pair result outside pair wait");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg == STAT_SATURATED |-> acc_reg == ENERGY_MAX)
        else $error("saturated status without clamped sum");

endmodule
`default_nettype wire

### hw/rtl/nre_pair_unit.sv
`default_nettype none
module nre_pair_unit (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire [nre_pkg::DIFF_W-1:0] ax,
    input  wire [nre_pkg::DIFF_W-1:0] ay,
    input  wire [nre_pkg::DIFF_W-1:0] az,
    input  wire [nre_pkg::QQ_W-1:0]   qq,
    output nre_pkg::pair_res_t        res
);
    import nre_pkg::*;

    pu_state_t            state_reg, state_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [1:0]           axis_reg, axis_next;
    logic [SUMSQ_W-1:0]   mcand_reg, mcand_next;
    logic [DIFF_W-1:0]    mplier_reg, mplier_next;
    logic [DIFF_W-1:0]    dy_reg, dy_next, dz_reg, dz_next;
    logic [SUMSQ_W-1:0]   sum_reg, sum_next;
    logic [ROOT_W+1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [TERM_W-1:0]    num_reg, num_next;
    logic [ROOT_W-1:0]    drem_reg, drem_next;
    logic                 zero_reg, zero_next;
    logic [ROOT_W+1:0]    rem_sh, trial;
    logic [ROOT_W:0]      div_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PU_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        axis_reg   <= axis_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        zero_reg   <= zero_next;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        zero_next   = zero_reg;
        rem_sh      = {rem_reg[ROOT_W-1:0], sum_reg[SUMSQ_W-1 -: 2]};
        trial       = {root_reg, 2'b01};
        div_sh      = {drem_reg, num_reg[TERM_W-1]};
        unique case (state_reg)
            PU_IDLE: begin
                if (start) begin
                    mcand_next  = {{(SUMSQ_W-DIFF_W){1'b0}}, ax};
                    mplier_next = ax;
                    dy_next     = ay;
                    dz_next     = az;
                    sum_next    = '0;
                    cnt_next    = '0;
                    axis_next   = '0;
                    num_next    = {qq, {COORD_W{1'b0}}};
                    state_next  = PU_SQ;
                end
            end
            PU_SQ: begin
                // shift-add one multiplier bit per cycle, summing all three squares
                if (mplier_reg[0]) begin
                    sum_next = sum_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[SUMSQ_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[DIFF_W-1:1]};
                cnt_next    = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIFF_W - 1)) begin
                    cnt_next  = '0;
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == 2'd0) begin
                        mcand_next  = {{(SUMSQ_W-DIFF_W){1'b0}}, dy_reg};
                        mplier_next = dy_reg;
                    end else if (axis_reg == 2'd1) begin
                        mcand_next  = {{(SUMSQ_W-DIFF_W){1'b0}}, dz_reg};
                        mplier_next = dz_reg;
                    end else begin
                        rem_next   = '0;
                        root_next  = '0;
                        state_next = PU_ROOT;
                    end
                end
            end
            PU_ROOT: begin
                // two radicand bits per step
                sum_next = {sum_reg[SUMSQ_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(SUMSQ_W / 2 - 1)) begin
                    cnt_next  = '0;
                    drem_next = '0;
                    if (root_next == '0) begin
                        zero_next  = 1'b1;
                        state_next = PU_DONE;
                    end else begin
                        zero_next  = 1'b0;
                        state_next = PU_DIV;
                    end
                end
            end
            PU_DIV: begin
                // restoring division, quotient bits enter at the bottom of num_reg
                if (div_sh >= {1'b0, root_reg}) begin
                    drem_next = ROOT_W'(div_sh - {1'b0, root_reg});
                    num_next  = {num_reg[TERM_W-2:0], 1'b1};
                end else begin
                    drem_next = div_sh[ROOT_W-1:0];
                    num_next  = {num_reg[TERM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(TERM_W - 1)) begin
                    state_next = PU_DONE;
                end
            end
            PU_DONE: begin
                state_next = PU_IDLE;
            end
            default: begin
                state_next = PU_IDLE;
            end
        endcase
    end

    assign res.done = (state_reg == PU_DONE);
    assign res.zero = zero_reg;
    assign res.term = num_reg;

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
import nre_pkg::*;

class energy_board;
    logic [47:0] exp_energy[$];
    logic [1:0]  exp_status[$];
    int errors;

    // held nuclei and running total of the current molecule
    logic signed [31:0] hx[$], hy[$], hz[$];
    logic [6:0] hq[$];
    logic [47:0] acc;
    logic [1:0]  stat;

    function new();
        errors = 0;
        acc = '0;
        stat = STAT_OK;
    endfunction

    function void raise(logic [1:0] s);
        if (s > stat) stat = s;
    endfunction

    function logic [33:0] root66(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] r;
        rem = '0;
        r = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {r, 2'b01};
            r = r << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function void note_nucleus(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic [6:0] q, logic lst);
        logic signed [33:0] dx, dy, dz;
        logic [65:0] d2;
        logic [33:0] d;
        logic [79:0] num, term;
        logic [48:0] sum;
        if (hx.size() >= MAX_NUCLEI) begin
            raise(STAT_TOO_MANY);
        end else begin
            for (int k = 0; k < hx.size(); k++) begin
                dx = $signed(x) - $signed(hx[k]);
                dy = $signed(y) - $signed(hy[k]);
                dz = $signed(z) - $signed(hz[k]);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dz < 0) dz = -dz;
                d2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
                d = root66(d2);
                if (d == 0) begin
                    raise(STAT_COINCIDENT);
                end else begin
                    num = (80'(q) * 80'(hq[k])) << 32;
                    term = num / 80'(d);
                    sum = 49'(acc) + 49'(term);
                    if (sum > 49'(ENERGY_MAX)) begin
                        acc = ENERGY_MAX;
                        raise(STAT_SATURATED);
                    end else begin
                        acc = sum[47:0];
                    end
                end
            end
            hx.push_back(x); hy.push_back(y); hz.push_back(z); hq.push_back(q);
        end
        if (lst) begin
            exp_energy.push_back(acc);
            exp_status.push_back(stat);
            hx.delete(); hy.delete(); hz.delete(); hq.delete();
            acc = '0;
            stat = STAT_OK;
        end
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endfunction

    function void check_result(logic [55:0] beat);
        logic [47:0] e;
        logic [1:0]  s;
        if (exp_energy.size() == 0) begin
            report("unexpected beat", beat, 0);
            return;
        end
        e = exp_energy.pop_front();
        s = exp_status.pop_front();
        if (beat[47:0] !== e) report("energy", beat[47:0], e);
        if (beat[49:48] !== s) report("status", beat[49:48], s);
    endfunction
endclass

module testbench;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic [103:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tready = 1'b0;
    wire  s_tready;
    wire  m_tvalid;
    wire [55:0] m_tdata;

    energy_board board = new();
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  mol_left = 0;
    bit  running = 1'b1;

    localparam int CYCLE_LIMIT = 6000000;

    always #5 aclk = ~aclk;

    nuclear_repulsion_energy dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: sample accepted beats, with random stall bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // valid stays high between back-to-back beats; drop it only for an idle burst
    task automatic send_nucleus(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [6:0] q, logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, q, z, y, x};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        board.note_nucleus(x, y, z, q, lst);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    initial begin
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single nucleus, extremes, coincident pair, zero charge
        send_nucleus(32'h0, 32'h0, 32'h0, 7'd1, 1'b1);
        send_nucleus(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd127, 1'b0);
        send_nucleus(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 7'd127, 1'b1);
        send_nucleus(32'h0001_0000, 32'h0, 32'h0, 7'd8, 1'b0);
        send_nucleus(32'h0001_0000, 32'h0, 32'h0, 7'd8, 1'b0);
        send_nucleus(32'h0, 32'h0, 32'h0, 7'd0, 1'b1);
        // closest distinct pairs with large charges saturate
        send_nucleus(32'h0, 32'h0, 32'h0, 7'd127, 1'b0);
        send_nucleus(32'h1, 32'h0, 32'h0, 7'd127, 1'b0);
        send_nucleus(32'h0, 32'h1, 32'h0, 7'd127, 1'b0);
        send_nucleus(32'h0, 32'h0, 32'h1, 7'd127, 1'b1);
        send_nucleus(32'h0, 32'h0, 32'h0, 7'd127, 1'b0);
        send_nucleus(32'h0, 32'h0, 32'h1, 7'd1, 1'b1);
        // overfill the store: 64 held, then extras are refused
        for (int i = 0; i < 67; i++)
            send_nucleus(32'(i) << 16, $urandom(), 32'h0, 7'($urandom_range(0, 127)),
                         i == 66);

        // random molecules, mostly small
        n = 0;
        while (n < 210) begin
            mol_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                   : $urandom_range(1, 4);
            if (n > 180) quiet = 1'b1;
            for (int j = 0; j < mol_left; j++) begin
                send_nucleus(rand_coord(), rand_coord(), rand_coord(),
                             7'($urandom_range(0, 127)), j == mol_left - 1);
                n++;
            end
        end
        s_tvalid <= 1'b0;

        while (board.exp_energy.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.exp_energy.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/nre_pkg.sv
hw/rtl/nre_pair_unit.sv
hw/rtl/nuclear_repulsion_energy.sv
tb/sv/testbench.sv
